// File: sv/sdsa_pkg.sv
`default_nettype none
package sdsa_pkg;

    // input request: one character of the line
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_line;
    } t_in_req;

    // output request: one result character
    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } t_out_req;

    typedef enum logic [3:0] {
        S_IN,
        S_CMP,
        S_ADD,
        S_SIGN,
        S_CARRY,
        S_INT,
        S_POINT,
        S_FRAC,
        S_NL
    } t_state;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [4:0] RADIX    = 5'd10;

endpackage
`default_nettype wire

// File: sv/sdsa_digit_alu.sv
`default_nettype none
// One decimal digit of add or subtract with carry/borrow.
module sdsa_digit_alu (
    input  wire logic [3:0] i_x,
    input  wire logic [3:0] i_y,
    input  wire logic       i_cin,
    input  wire logic       i_sub,
    output logic      [3:0] o_d,
    output logic            o_cout
);

    logic [4:0] y5;
    logic [4:0] x5;
    logic [4:0] s5;

    assign y5 = {1'b0, i_y} + {4'd0, i_cin};
    assign x5 = {1'b0, i_x};
    assign s5 = x5 + y5;

    always_comb begin
        if (i_sub) begin
            if (x5 < y5) begin
                o_cout = 1'b1;
                o_d    = 4'(x5 + sdsa_pkg::RADIX - y5);
            end else begin
                o_cout = 1'b0;
                o_d    = 4'(x5 - y5);
            end
        end else begin
            if (s5 >= sdsa_pkg::RADIX) begin
                o_cout = 1'b1;
                o_d    = 4'(s5 - sdsa_pkg::RADIX);
            end else begin
                o_cout = 1'b0;
                o_d    = s5[3:0];
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/signed_decimal_string_adder.sv
// Signed decimal string adder.
// Input channel (i_valid, o_stall, i_data): one character per request; the
// line holds two signed decimal numbers split by the first space, and
// end_of_line marks its last character. Characters are taken one per cycle
// while o_stall is low. Output channel (o_valid, i_stall, o_data): result
// characters: optional '-', optional carry '1', integer digits, '.' and
// fraction digits when there are any, then a newline with last set. Bad
// lines give no output. Steps: when the signs differ, a magnitude compare,
// most significant first, of the aligned digits (integer plus fraction);
// then a least-significant-first add/subtract through one digit unit; then
// one character per cycle while the receiver does not stall. The digit unit
// and the single result-store port set the cost of a line. o_stall is high
// from the end of a good line until its newline is loaded into the output
// register. A stalled receiver holds the output register and pauses emission.
// Reset (synchronous, active low) returns to waiting for a new line and
// empties the output register.
`default_nettype none
module signed_decimal_string_adder #(
    parameter int INT_DIGITS  = 16,
    parameter int FRAC_DIGITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire sdsa_pkg::t_in_req  i_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output sdsa_pkg::t_out_req      o_data
);

    localparam int ALL = INT_DIGITS + FRAC_DIGITS;
    localparam int IA  = (INT_DIGITS > 1) ? $clog2(INT_DIGITS) : 1;
    localparam int FA  = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;
    localparam int ICW = $clog2(INT_DIGITS + 1);
    localparam int FCW = $clog2(FRAC_DIGITS + 1);
    localparam int PW  = $clog2(ALL + 1);
    localparam int RA  = $clog2(ALL);

    // digit stores
    logic [3:0] r_lis [INT_DIGITS];
    logic [3:0] r_ris [INT_DIGITS];
    logic [3:0] r_lfs [FRAC_DIGITS];
    logic [3:0] r_rfs [FRAC_DIGITS];
    logic [3:0] r_res [ALL];

    // line state
    logic [ICW-1:0] r_lic, n_lic, r_ric, n_ric;
    logic [FCW-1:0] r_lfc, n_lfc, r_rfc, n_rfc;
    logic r_lm, n_lm, r_rm, n_rm;
    logic r_right, n_right, r_start, n_start, r_ps, n_ps, r_pjs, n_pjs;
    logic r_bad, n_bad;

    sdsa_pkg::t_state r_state, n_state;
    logic [PW-1:0] r_p, n_p, r_e, n_e;
    logic r_ll, n_ll, r_carry, n_carry;
    logic r_ov, n_ov;
    sdsa_pkg::t_out_req r_od, n_od;

    // store write controls
    logic           we_int, we_frac;
    logic [IA-1:0]  wa_int;
    logic [FA-1:0]  wa_frac;
    logic [3:0]     wd;

    logic in_acc, slot, has, adv;
    logic [7:0] ch;
    logic [7:0] emit_ch;
    logic       emit_last;
    logic sub, neg, swap;
    logic [PW-1:0] w, f, n, q;
    logic [3:0] da, db, ax, by, alu_d;
    logic alu_c;
    logic [3:0] res_rd;

    assign ch      = i_data.char_in;
    assign o_stall = (r_state != sdsa_pkg::S_IN);
    assign in_acc  = i_valid && !o_stall;
    assign slot    = !r_ov || !i_stall;
    assign adv     = !has || slot;
    assign o_valid = r_ov;
    assign o_data  = r_od;

    // aligned widths
    assign w    = (r_lic > r_ric) ? PW'(r_lic) : PW'(r_ric);
    assign f    = (r_lfc > r_rfc) ? PW'(r_lfc) : PW'(r_rfc);
    assign n    = w + f;
    assign sub  = (r_lm != r_rm);
    assign swap = sub && !r_ll;
    assign neg  = sub ? (r_ll ? r_lm : r_rm) : r_lm;
    assign q    = (r_state == sdsa_pkg::S_ADD) ? r_p - PW'(1) : r_p;

    // aligned digit of each number at position q
    always_comb begin
        logic [PW-1:0] pad_l, pad_r, qf;
        pad_l = w - PW'(r_lic);
        pad_r = w - PW'(r_ric);
        qf    = q - w;
        if (q < w) begin
            da = (q < pad_l) ? 4'd0 : r_lis[IA'(q - pad_l)];
            db = (q < pad_r) ? 4'd0 : r_ris[IA'(q - pad_r)];
        end else begin
            da = (qf < PW'(r_lfc)) ? r_lfs[FA'(qf)] : 4'd0;
            db = (qf < PW'(r_rfc)) ? r_rfs[FA'(qf)] : 4'd0;
        end
    end

    assign ax = swap ? db : da;
    assign by = swap ? da : db;

    sdsa_digit_alu u_alu (
        .i_x    (ax),
        .i_y    (by),
        .i_cin  (r_carry),
        .i_sub  (sub),
        .o_d    (alu_d),
        .o_cout (alu_c)
    );

    assign res_rd = r_res[RA'(r_e)];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sdsa_pkg::S_IN: begin
                if (in_acc && i_data.end_of_line && !n_bad && n_right) begin
                    n_state = sdsa_pkg::S_CMP;
                end
            end
            sdsa_pkg::S_CMP: begin
                if (!sub || r_p >= n || da != db) begin
                    n_state = sdsa_pkg::S_ADD;
                end
            end
            sdsa_pkg::S_ADD: begin
                if (r_p == '0) begin
                    n_state = sdsa_pkg::S_SIGN;
                end
            end
            sdsa_pkg::S_SIGN:  if (adv) n_state = sdsa_pkg::S_CARRY;
            sdsa_pkg::S_CARRY: if (adv) n_state = sdsa_pkg::S_INT;
            sdsa_pkg::S_INT:   if (r_e >= w) n_state = sdsa_pkg::S_POINT;
            sdsa_pkg::S_POINT: if (adv) n_state = sdsa_pkg::S_FRAC;
            sdsa_pkg::S_FRAC:  if (r_e >= n) n_state = sdsa_pkg::S_NL;
            sdsa_pkg::S_NL:    if (adv) n_state = sdsa_pkg::S_IN;
            default:           n_state = sdsa_pkg::S_IN;
        endcase
    end

    // emitted character per state
    always_comb begin
        has       = 1'b0;
        emit_ch   = sdsa_pkg::CH_NL;
        emit_last = 1'b0;
        case (r_state)
            sdsa_pkg::S_SIGN: begin
                has     = neg;
                emit_ch = sdsa_pkg::CH_MINUS;
            end
            sdsa_pkg::S_CARRY: begin
                has     = !sub && r_carry;
                emit_ch = sdsa_pkg::CH_ONE;
            end
            sdsa_pkg::S_INT, sdsa_pkg::S_FRAC: begin
                has     = (r_state == sdsa_pkg::S_INT) ? (r_e < w) : (r_e < n);
                emit_ch = sdsa_pkg::CH_ZERO + {4'd0, res_rd};
            end
            sdsa_pkg::S_POINT: begin
                has     = (f != '0);
                emit_ch = sdsa_pkg::CH_POINT;
            end
            sdsa_pkg::S_NL: begin
                has       = 1'b1;
                emit_last = 1'b1;
            end
            default: has = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        n_lic = r_lic; n_ric = r_ric; n_lfc = r_lfc; n_rfc = r_rfc;
        n_lm = r_lm; n_rm = r_rm; n_right = r_right; n_start = r_start;
        n_ps = r_ps; n_pjs = r_pjs; n_bad = r_bad;
        n_p = r_p; n_e = r_e; n_ll = r_ll; n_carry = r_carry;
        we_int = 1'b0; we_frac = 1'b0;
        wa_int = r_right ? IA'(r_ric) : IA'(r_lic);
        wa_frac = r_right ? FA'(r_rfc) : FA'(r_lfc);
        wd = 4'(ch - sdsa_pkg::CH_ZERO);
        n_ov = r_ov && i_stall;
        n_od = r_od;

        // character parsing
        if (r_state == sdsa_pkg::S_IN && in_acc) begin
            if (!r_bad) begin
                if (ch == sdsa_pkg::CH_SPACE) begin
                    if (r_right || r_pjs) begin
                        n_bad = 1'b1;
                    end else begin
                        n_right = 1'b1;
                        n_start = 1'b1;
                        n_ps    = 1'b0;
                        n_pjs   = 1'b0;
                    end
                end else if (r_start && (ch == sdsa_pkg::CH_MINUS ||
                                         ch == sdsa_pkg::CH_PLUS)) begin
                    if (r_right) n_rm = (ch == sdsa_pkg::CH_MINUS);
                    else n_lm = (ch == sdsa_pkg::CH_MINUS);
                    n_start = 1'b0;
                end else begin
                    n_start = 1'b0;
                    if (ch == sdsa_pkg::CH_POINT && !r_ps) begin
                        n_ps  = 1'b1;
                        n_pjs = 1'b1;
                    end else if (ch >= sdsa_pkg::CH_ZERO && ch <= sdsa_pkg::CH_NINE) begin
                        n_pjs = 1'b0;
                        if (r_ps) begin
                            if ((r_right ? r_rfc : r_lfc) == FCW'(FRAC_DIGITS)) begin
                                n_bad = 1'b1;
                            end else begin
                                we_frac = 1'b1;
                                if (r_right) n_rfc = r_rfc + FCW'(1);
                                else n_lfc = r_lfc + FCW'(1);
                            end
                        end else begin
                            if ((r_right ? r_ric : r_lic) == ICW'(INT_DIGITS)) begin
                                n_bad = 1'b1;
                            end else begin
                                we_int = 1'b1;
                                if (r_right) n_ric = r_ric + ICW'(1);
                                else n_lic = r_lic + ICW'(1);
                            end
                        end
                    end else begin
                        n_bad = 1'b1;
                    end
                end
            end
            if (i_data.end_of_line) begin
                if (n_pjs) n_bad = 1'b1;
                n_p     = '0;
                n_carry = 1'b0;
                n_ll    = 1'b0;
                if (n_bad || !n_right) begin
                    n_lic = '0; n_ric = '0; n_lfc = '0; n_rfc = '0;
                    n_lm = 1'b0; n_rm = 1'b0; n_right = 1'b0; n_start = 1'b1;
                    n_ps = 1'b0; n_pjs = 1'b0; n_bad = 1'b0;
                end
            end
        end

        // compare, most significant first
        if (r_state == sdsa_pkg::S_CMP) begin
            if (!sub || r_p >= n) begin
                n_p = n;
            end else if (da != db) begin
                n_ll = (da > db);
                n_p  = n;
            end else begin
                n_p = r_p + PW'(1);
            end
        end

        // add/subtract, least significant first
        if (r_state == sdsa_pkg::S_ADD) begin
            if (r_p != '0) begin
                n_carry = alu_c;
                n_p     = r_p - PW'(1);
            end else begin
                n_e = '0;
            end
        end

        // output register load
        if (has && slot) begin
            n_ov = 1'b1;
            n_od.char_out = emit_ch;
            n_od.last     = emit_last;
            if (r_state == sdsa_pkg::S_INT || r_state == sdsa_pkg::S_FRAC) begin
                n_e = r_e + PW'(1);
            end
        end

        // line done
        if (r_state == sdsa_pkg::S_NL && adv) begin
            n_lic = '0; n_ric = '0; n_lfc = '0; n_rfc = '0;
            n_lm = 1'b0; n_rm = 1'b0; n_right = 1'b0; n_start = 1'b1;
            n_ps = 1'b0; n_pjs = 1'b0; n_bad = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdsa_pkg::S_IN;
            r_lic <= '0; r_ric <= '0; r_lfc <= '0; r_rfc <= '0;
            r_lm <= 1'b0; r_rm <= 1'b0; r_right <= 1'b0; r_start <= 1'b1;
            r_ps <= 1'b0; r_pjs <= 1'b0; r_bad <= 1'b0;
            r_p <= '0; r_e <= '0; r_ll <= 1'b0; r_carry <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lic <= n_lic; r_ric <= n_ric; r_lfc <= n_lfc; r_rfc <= n_rfc;
            r_lm <= n_lm; r_rm <= n_rm; r_right <= n_right; r_start <= n_start;
            r_ps <= n_ps; r_pjs <= n_pjs; r_bad <= n_bad;
            r_p <= n_p; r_e <= n_e; r_ll <= n_ll; r_carry <= n_carry;
            r_ov <= n_ov;
        end
    end

    // payload and stores
    always_ff @(posedge i_clk) begin
        r_od <= n_od;
        if (we_int) begin
            if (r_right) r_ris[wa_int] <= wd;
            else r_lis[wa_int] <= wd;
        end
        if (we_frac) begin
            if (r_right) r_rfs[wa_frac] <= wd;
            else r_lfs[wa_frac] <= wd;
        end
        if (r_state == sdsa_pkg::S_ADD && r_p != '0) begin
            r_res[RA'(r_p - PW'(1))] <= alu_d;
        end
    end

`ifndef SYNTH
    a_cmp_only_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdsa_pkg::S_CMP && r_p != '0) |-> sub)
        else $error("compare pass without a subtract");
    a_add_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdsa_pkg::S_ADD) |-> (r_p <= n))
        else $error("add position beyond digit count");
    a_int_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdsa_pkg::S_INT) |-> (r_e <= w))
        else $error("integer emit index beyond width");
    a_nl_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sdsa_pkg::S_NL && slot) |=> (r_ov && r_od.last))
        else $error("newline not loaded with last");
`endif

endmodule
`default_nettype wire
